// File: design/pnd_pkg.sv
// Package for the 2D gradient noise unit: hash constants, pipeline stage count,
// and the elaboration-time quarter-wave sine generator used to build the gradient ROM.
// No dependencies.
package pnd_pkg;

  localparam int NUM_STAGES = 10;

  typedef logic [NUM_STAGES:1] stage_en_t;

  localparam logic [31:0] HASH_MUL1 = 32'd3284157443;
  localparam logic [31:0] HASH_MUL2 = 32'd1911520717;
  localparam logic [31:0] HASH_MUL3 = 32'd2048419325;

  // pi/2 in Q30 radians.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor series divisors (2k+2)(2k+3).
  localparam longint unsigned SERIES_DIV [11] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342,
      64'd420, 64'd506};

  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // Sine of quarter step r, signed with trig_bits-1 fraction bits.
  // Only evaluated at elaboration to fill the ROM.
  function automatic longint quarter_sine(input int r, input int angle_bits,
                                          input int trig_bits);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned q_steps;
    longint          sum;
    longint          res;
    longint          maxv;
    q_steps = 64'd1 << (angle_bits - 2);
    theta = (64'(r) * HALF_PI_Q30 + (q_steps >> 1)) >> (angle_bits - 2);
    t2 = (theta * theta + (64'd1 << 29)) >> 30;
    term = theta;
    sum = 0;
    maxv = (64'sd1 <<< (trig_bits - 1)) - 64'sd1;
    for (int k = 0; k <= 10; k++) begin
      if (k % 2 == 0) begin
        sum = sum + signed'(term);
      end else begin
        sum = sum - signed'(term);
      end
      term = ((term * t2 + (64'd1 << 29)) >> 30) / SERIES_DIV[k];
    end
    if (sum < 0) begin
      sum = 0;
    end
    res = signed'((unsigned'(sum) + (64'd1 << (29 - (trig_bits - 1))))
                  >> (30 - (trig_bits - 1)));
    return (res > maxv) ? maxv : res;
  endfunction

endpackage

// File: design/perlin_noise_2d_unit.sv
// Top level of the 2D gradient noise unit: stage valid/enable control and the
// four pipeline parts. Depends on pnd_pkg, pnd_hash, pnd_smooth, pnd_grad, pnd_blend.
//
// Usage:
//   The input stream carries one coordinate pair per item: s_axis_tdata holds x_pos
//   in bits 31:0 and y_pos in bits 63:32, both unsigned with FRAC_BITS fraction bits.
//   The output stream carries one noise value per item in m_axis_tdata[15:0], Q0.16.
//   Items leave in the order they entered, exactly one result for each input item.
//   The result path holds ten register stages: three of hashing, one of ROM lookup,
//   two of dot product and four of blend.
//   Throughput is one item per clock while the output is taken.
//   Each stage holds its item when the stage after it is full and stalled, and empty
//   stages keep filling, so a stalled receiver only backs up the input once all ten
//   stages hold items; no item is lost or repeated.
//   A synchronous reset clears all stage valid bits; the data registers are not reset,
//   and the output carries no item until new input arrives.
module perlin_noise_2d_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int INT_BITS   = 16,
  parameter int ANGLE_BITS = 10,
  parameter int TRIG_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_pos [31:0], y_pos [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // noise_value [15:0]
);

  localparam int NS = pnd_pkg::NUM_STAGES;
  localparam logic [31:0] IMASK = 32'((64'd1 << INT_BITS) - 64'd1);

  pnd_pkg::stage_en_t en;
  logic [NS:1]        vld;

  // A stage may load when it is empty or its item moves on in the same cycle.
  always_comb begin
    en[NS] = !vld[NS] || m_axis_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld[NS];

  logic [31:0]           x_int;
  logic [31:0]           y_int;
  logic [FRAC_BITS-1:0]  fx0;
  logic [FRAC_BITS-1:0]  fy0;

  assign x_int = (s_axis_tdata[31:0] >> FRAC_BITS) & IMASK;
  assign y_int = (s_axis_tdata[63:32] >> FRAC_BITS) & IMASK;
  assign fx0 = s_axis_tdata[FRAC_BITS-1:0];
  assign fy0 = s_axis_tdata[32 +: FRAC_BITS];

  // Fractions ride along with the hash until the gradients are looked up.
  logic [FRAC_BITS-1:0] fx_d [3];
  logic [FRAC_BITS-1:0] fy_d [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fx_d[0] <= fx0;
      fy_d[0] <= fy0;
    end
    for (int k = 1; k < 3; k++) begin
      if (en[k + 1]) begin
        fx_d[k] <= fx_d[k - 1];
        fy_d[k] <= fy_d[k - 1];
      end
    end
  end

  logic [ANGLE_BITS-1:0]       idx [4];
  logic [FRAC_BITS+1:0]        sx;
  logic [FRAC_BITS+1:0]        sy;
  logic signed [FRAC_BITS+2:0] dot [4];

  pnd_hash #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_hash (
    .clk   (clk),
    .en    (en),
    .x_int (x_int),
    .y_int (y_int),
    .idx   (idx)
  );

  pnd_smooth #(
    .FRAC_BITS(FRAC_BITS)
  ) u_smooth (
    .clk (clk),
    .en  (en),
    .fx  (fx0),
    .fy  (fy0),
    .sx  (sx),
    .sy  (sy)
  );

  pnd_grad #(
    .FRAC_BITS (FRAC_BITS),
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_grad (
    .clk (clk),
    .en  (en),
    .idx (idx),
    .fx  (fx_d[2]),
    .fy  (fy_d[2]),
    .dot (dot)
  );

  pnd_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk         (clk),
    .en          (en),
    .dot         (dot),
    .sx          (sx),
    .sy          (sy),
    .noise_value (m_axis_tdata)
  );

  // Input is refused only when every stage holds an item.
  a_full_when_refused: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&vld))
    else $error("input refused while the pipeline has an empty stage");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input refused while the output is being taken");

  a_mid_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && !en[5]) |=> vld[5])
    else $error("a stalled stage lost its item");

  // Checked at the first edge after reset is released.
  a_empty_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("output item present right after reset");

endmodule

// File: design/pnd_hash.sv
// Corner hash for the noise unit: rotate-xor-multiply hash of the four cell corners,
// three register stages (stages 1 to 3), giving the gradient angle index of each corner.
// Depends on pnd_pkg.
module pnd_hash #(
  parameter int ANGLE_BITS = 10
) (
  input  logic                   clk,
  input  pnd_pkg::stage_en_t     en,
  input  logic [31:0]            x_int,
  input  logic [31:0]            y_int,
  output logic [ANGLE_BITS-1:0]  idx [4]
);

  logic [31:0] ax [2];
  logic [31:0] cy [2];
  logic [31:0] a2 [4];
  logic [31:0] b2 [4];
  logic [31:0] h3 [4];

  // Stage 1: first multiply for both x corners.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ax[0] <= x_int * pnd_pkg::HASH_MUL1;
      ax[1] <= (x_int + 32'd1) * pnd_pkg::HASH_MUL1;
      cy[0] <= y_int;
      cy[1] <= y_int + 32'd1;
    end
  end

  // Stage 2: mix in y. Corner bit 0 selects x + 1, bit 1 selects y + 1.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 4; c++) begin
        b2[c] <= (cy[c / 2] ^ pnd_pkg::rotl16(ax[c % 2])) * pnd_pkg::HASH_MUL2;
        a2[c] <= ax[c % 2];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h3[c] = (a2[c] ^ pnd_pkg::rotl16(b2[c])) * pnd_pkg::HASH_MUL3;
    end
  end

  // Stage 3: final multiply; the top bits pick the gradient angle.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 4; c++) begin
        idx[c] <= h3[c][31 -: ANGLE_BITS];
      end
    end
  end

endmodule

// File: design/pnd_smooth.sv
// Smoothstep fade weights 3f^2 - 2f^3 for the x and y fractions, stages 1 to 4,
// then carried to stage 6 to meet the corner dot products. Depends on pnd_pkg.
module pnd_smooth #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  pnd_pkg::stage_en_t   en,
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  output logic [FRAC_BITS+1:0] sx,
  output logic [FRAC_BITS+1:0] sy
);

  localparam int FB = FRAC_BITS;
  localparam int SQW = 2 * FB;
  localparam int PW = 2 * FB + 3;
  localparam logic [SQW:0]   HALF_SQ = (SQW + 1)'(1) << (FB - 1);
  localparam logic [PW-1:0]  HALF_P = PW'(1) << (FB - 1);
  localparam logic [FB+1:0]  THREE_ONE = (FB + 2)'(3) << FB;

  logic [FB-1:0]  fin [2];
  logic [SQW-1:0] sq  [2];
  logic [FB-1:0]  f1  [2];
  logic [FB:0]    w2  [2];
  logic [FB+1:0]  m2  [2];
  logic [PW-1:0]  p3  [2];
  logic [FB+1:0]  s4  [2];
  logic [FB+1:0]  s5  [2];
  logic [FB+1:0]  s6  [2];

  assign fin[0] = fx;
  assign fin[1] = fy;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en[1]) begin
        sq[l] <= SQW'(fin[l]) * SQW'(fin[l]);
        f1[l] <= fin[l];
      end
      if (en[2]) begin
        w2[l] <= (FB + 1)'(({1'b0, sq[l]} + HALF_SQ) >> FB);
        m2[l] <= THREE_ONE - (FB + 2)'({f1[l], 1'b0});
      end
      if (en[3]) begin
        p3[l] <= PW'(w2[l]) * PW'(m2[l]);
      end
      if (en[4]) begin
        s4[l] <= (FB + 2)'((p3[l] + HALF_P) >> FB);
      end
      if (en[5]) begin
        s5[l] <= s4[l];
      end
      if (en[6]) begin
        s6[l] <= s5[l];
      end
    end
  end

  assign sx = s6[0];
  assign sy = s6[1];

endmodule

// File: design/pnd_grad.sv
// Gradient lookup and corner dot products, stages 4 to 6: quarter-wave sine ROM
// built at elaboration, sin/cos per corner, then dx*sin + dy*cos rounded. Depends on pnd_pkg.
module pnd_grad #(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 10,
  parameter int TRIG_BITS  = 16
) (
  input  logic                        clk,
  input  pnd_pkg::stage_en_t          en,
  input  logic [ANGLE_BITS-1:0]       idx [4],
  input  logic [FRAC_BITS-1:0]        fx,
  input  logic [FRAC_BITS-1:0]        fy,
  output logic signed [FRAC_BITS+2:0] dot [4]
);

  localparam int QTR = 1 << (ANGLE_BITS - 2);
  localparam int AW = ANGLE_BITS - 1;
  localparam int PW = FRAC_BITS + 1 + TRIG_BITS;
  localparam int DW = FRAC_BITS + 3;
  localparam logic signed [PW:0] RND_T = (PW + 1)'(1) <<< (TRIG_BITS - 2);

  logic signed [TRIG_BITS-1:0] qsin [QTR+1];

  for (genvar r = 0; r <= QTR; r++) begin : g_rom
    assign qsin[r] = TRIG_BITS'(pnd_pkg::quarter_sine(r, ANGLE_BITS, TRIG_BITS));
  end

  logic [1:0]                  quad_s [4];
  logic [1:0]                  quad_c [4];
  logic [ANGLE_BITS-3:0]       rpos   [4];
  logic [AW-1:0]               addr_s [4];
  logic [AW-1:0]               addr_c [4];
  logic signed [TRIG_BITS-1:0] gs_v   [4];
  logic signed [TRIG_BITS-1:0] gc_v   [4];

  // Odd quadrants read the ROM mirrored, the lower half-turn is negated.
  // Cosine is the sine a quarter turn ahead.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      quad_s[c] = idx[c][ANGLE_BITS-1 -: 2];
      quad_c[c] = quad_s[c] + 2'd1;
      rpos[c] = idx[c][ANGLE_BITS-3:0];
      addr_s[c] = quad_s[c][0] ? (AW'(QTR) - AW'(rpos[c])) : AW'(rpos[c]);
      addr_c[c] = quad_c[c][0] ? (AW'(QTR) - AW'(rpos[c])) : AW'(rpos[c]);
      gs_v[c] = quad_s[c][1] ? -qsin[addr_s[c]] : qsin[addr_s[c]];
      gc_v[c] = quad_c[c][1] ? -qsin[addr_c[c]] : qsin[addr_c[c]];
    end
  end

  logic signed [TRIG_BITS-1:0] gs4 [4];
  logic signed [TRIG_BITS-1:0] gc4 [4];
  logic [FRAC_BITS-1:0]        fx4;
  logic [FRAC_BITS-1:0]        fy4;
  logic signed [FRAC_BITS:0]   dxv [4];
  logic signed [FRAC_BITS:0]   dyv [4];
  logic signed [PW-1:0]        ps5 [4];
  logic signed [PW-1:0]        pc5 [4];
  logic signed [PW:0]          dsum [4];

  // Far corners sit one unit away, so their offset is f - 1.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dxv[c] = $signed({1'(c % 2), fx4});
      dyv[c] = $signed({1'(c / 2), fy4});
      dsum[c] = (PW + 1)'(ps5[c]) + (PW + 1)'(pc5[c]) + RND_T;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      gs4 <= gs_v;
      gc4 <= gc_v;
      fx4 <= fx;
      fy4 <= fy;
    end
    if (en[5]) begin
      for (int c = 0; c < 4; c++) begin
        ps5[c] <= dxv[c] * gs4[c];
        pc5[c] <= dyv[c] * gc4[c];
      end
    end
    if (en[6]) begin
      for (int c = 0; c < 4; c++) begin
        dot[c] <= DW'(dsum[c] >>> (TRIG_BITS - 1));
      end
    end
  end

endmodule

// File: design/pnd_blend.sv
// Bilinear smoothstep blend, stages 7 to 10: x blend of both rows, y blend,
// then rescale of (v + 1) / 2 to Q0.16 with saturation. Depends on pnd_pkg.
module pnd_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  pnd_pkg::stage_en_t          en,
  input  logic signed [FRAC_BITS+2:0] dot [4],
  input  logic [FRAC_BITS+1:0]        sx,
  input  logic [FRAC_BITS+1:0]        sy,
  output logic [15:0]                 noise_value
);

  localparam int FB = FRAC_BITS;
  localparam int DW = FB + 3;
  localparam int PT = 2 * FB + 7;
  localparam int SH_R = (FB > 15) ? FB - 15 : 0;
  localparam int SH_L = (FB < 15) ? 15 - FB : 0;
  localparam logic signed [PT-1:0] RND_F = PT'((1 << FB) >> 1);
  localparam logic signed [PT-1:0] ONE_F = PT'(1 << FB);
  localparam logic signed [PT-1:0] RND_O = PT'((1 << SH_R) >> 1);

  logic signed [DW:0]   dtop;
  logic signed [DW:0]   dbot;
  logic signed [PT-1:0] sxs;
  logic signed [PT-1:0] pt7;
  logic signed [PT-1:0] pb7;
  logic signed [DW-1:0] d0_7;
  logic signed [DW-1:0] d2_7;
  logic [FB+1:0]        sy7;
  logic signed [DW-1:0] top8;
  logic signed [DW-1:0] bot8;
  logic [FB+1:0]        sy8;
  logic signed [DW:0]   dv;
  logic signed [PT-1:0] sys;
  logic signed [PT-1:0] pv9;
  logic signed [DW-1:0] top9;
  logic signed [PT-1:0] vsum;
  logic signed [PT-1:0] tval;
  logic signed [PT-1:0] oval;
  logic [15:0]          sat;

  always_comb begin
    dtop = (DW + 1)'(dot[1]) - (DW + 1)'(dot[0]);
    dbot = (DW + 1)'(dot[3]) - (DW + 1)'(dot[2]);
    sxs = $signed(PT'(sx));
    dv = (DW + 1)'(bot8) - (DW + 1)'(top8);
    sys = $signed(PT'(sy8));
    vsum = PT'(top9) + ((pv9 + RND_F) >>> FB);
    tval = vsum + ONE_F;
    oval = ((tval + RND_O) >>> SH_R) <<< SH_L;
    if (oval < 0) begin
      sat = 16'd0;
    end else if (oval > 65535) begin
      sat = 16'hFFFF;
    end else begin
      sat = oval[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      pt7 <= PT'(dtop) * sxs;
      pb7 <= PT'(dbot) * sxs;
      d0_7 <= dot[0];
      d2_7 <= dot[2];
      sy7 <= sy;
    end
    if (en[8]) begin
      top8 <= DW'(PT'(d0_7) + ((pt7 + RND_F) >>> FB));
      bot8 <= DW'(PT'(d2_7) + ((pb7 + RND_F) >>> FB));
      sy8 <= sy7;
    end
    if (en[9]) begin
      pv9 <= PT'(dv) * sys;
      top9 <= top8;
    end
    if (en[10]) begin
      noise_value <= sat;
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for perlin_noise_2d_unit: drives coordinate pairs and
// compares each noise value with a fixed-point gradient noise predictor kept here or a pinned value.
// Depends on the design files (perlin_noise_2d_unit and the parts and package it uses) only.
module testbench;

  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 16;
  localparam int ANGLE_BITS = 10;
  localparam int TRIG_BITS  = 16;

  localparam int QUARTER_STEPS = 1 << (ANGLE_BITS - 2);
  localparam longint ONE_F = longint'(1) << FRAC_BITS;
  localparam longint HALF_F = longint'(1) << (FRAC_BITS - 1);
  localparam longint HALF_TRIG = longint'(1) << (TRIG_BITS - 2);
  localparam logic [31:0] FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;
  localparam logic [31:0] INT_MASK = (32'd1 << INT_BITS) - 32'd1;
  localparam logic [31:0] CELL_MUL_X = 32'd3284157443;
  localparam logic [31:0] CELL_MUL_Y = 32'd1911520717;
  localparam logic [31:0] CELL_MUL_MIX = 32'd2048419325;
  localparam longint unsigned QUARTER_PI_RAD_Q30 = 64'd1686629713;
  localparam logic [15:0] LATTICE_NOISE = 16'd32768;
  localparam int RANDOM_ITEMS = 850;

  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic        pinned;
    logic [15:0] noise;
  } coord_row_t;

  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [15:0] noise;
  } noise_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = 64'd0;   // x_pos [31:0], y_pos [63:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // noise_value [15:0]

  longint        quarter_sine_rom [0:QUARTER_STEPS];
  noise_expect_t noise_expect_q [$];
  int            mismatch_count = 0;
  int            noise_checked = 0;
  int            coords_sent = 0;
  bit            quiet_tail = 1'b0;
  bit            sender_idles = 1'b1;

  // Integer lattice points give zero noise, which reads as one half.
  coord_row_t directed_rows [16] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, LATTICE_NOISE},
    '{32'hFFFF_0000, 32'hFFFF_0000, 1'b1, LATTICE_NOISE},
    '{32'h0005_0000, 32'h0003_0000, 1'b1, LATTICE_NOISE},
    '{32'h0001_0000, 32'hFFFF_0000, 1'b1, LATTICE_NOISE},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0},
    '{32'h0000_FFFF, 32'h0000_0000, 1'b0, 16'd0},
    '{32'h0000_0000, 32'h0000_FFFF, 1'b0, 16'd0},
    '{32'h0000_8000, 32'h0000_8000, 1'b0, 16'd0},
    '{32'hFFFF_8000, 32'h1234_8000, 1'b0, 16'd0},
    '{32'h0000_0001, 32'h0000_0001, 1'b0, 16'd0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 16'd0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 16'd0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'd0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'd0},
    '{32'h7FFF_7FFF, 32'h8000_8000, 1'b0, 16'd0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 16'd0}
  };

  perlin_noise_2d_unit #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS),
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Taylor series for sin over the first quadrant, in Q30 radians.
  function automatic longint quarter_sine_entry(input int r);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint          acc;
    longint          res;
    longint          maxv;
    theta = (longint'(r) * QUARTER_PI_RAD_Q30 + longint'(QUARTER_STEPS / 2))
            >> (ANGLE_BITS - 2);
    t2 = (theta * theta + (64'd1 << 29)) >> 30;
    term = theta;
    acc = 0;
    maxv = (longint'(1) << (TRIG_BITS - 1)) - 1;
    for (int k = 0; k <= 10; k++) begin
      if (k % 2 == 0) begin
        acc = acc + longint'(term);
      end else begin
        acc = acc - longint'(term);
      end
      term = ((term * t2 + (64'd1 << 29)) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
    end
    if (acc < 0) begin
      acc = 0;
    end
    res = (acc + (longint'(1) << (29 - (TRIG_BITS - 1)))) >>> (30 - (TRIG_BITS - 1));
    return (res > maxv) ? maxv : res;
  endfunction

  function automatic longint gradient_sine(input logic [ANGLE_BITS-1:0] angle);
    logic [1:0] quad;
    int         r;
    longint     m;
    quad = angle[ANGLE_BITS-1 -: 2];
    r = int'(angle[ANGLE_BITS-3:0]);
    m = quad[0] ? quarter_sine_rom[QUARTER_STEPS - r] : quarter_sine_rom[r];
    return quad[1] ? -m : m;
  endfunction

  function automatic longint corner_gradient_dot(input logic [31:0] cx, input logic [31:0] cy,
                                                 input longint dx, input longint dy);
    logic [31:0]           ha;
    logic [31:0]           hb;
    logic [ANGLE_BITS-1:0] angle;
    logic [ANGLE_BITS-1:0] angle_cos;
    longint                gs;
    longint                gc;
    ha = cx * CELL_MUL_X;
    hb = cy ^ {ha[15:0], ha[31:16]};
    hb = hb * CELL_MUL_Y;
    ha = ha ^ {hb[15:0], hb[31:16]};
    ha = ha * CELL_MUL_MIX;
    angle = ha[31 -: ANGLE_BITS];
    angle_cos = angle + QUARTER_STEPS[ANGLE_BITS-1:0];
    gs = gradient_sine(angle);
    gc = gradient_sine(angle_cos);
    return (dx * gs + dy * gc + HALF_TRIG) >>> (TRIG_BITS - 1);
  endfunction

  function automatic longint smoothstep_weight(input longint f);
    longint w2;
    w2 = (f * f + HALF_F) >>> FRAC_BITS;
    return (w2 * (3 * ONE_F - 2 * f) + HALF_F) >>> FRAC_BITS;
  endfunction

  function automatic longint lerp_weighted(input longint a0, input longint a1, input longint s);
    return a0 + (((a1 - a0) * s + HALF_F) >>> FRAC_BITS);
  endfunction

  function automatic logic [15:0] predict_noise(input logic [31:0] xp, input logic [31:0] yp);
    logic [31:0] x0;
    logic [31:0] y0;
    longint      fx;
    longint      fy;
    longint      sx;
    longint      sy;
    longint      top_row;
    longint      bot_row;
    longint      mixed;
    longint      scaled;
    x0 = (xp >> FRAC_BITS) & INT_MASK;
    y0 = (yp >> FRAC_BITS) & INT_MASK;
    fx = longint'(xp & FRAC_MASK);
    fy = longint'(yp & FRAC_MASK);
    sx = smoothstep_weight(fx);
    sy = smoothstep_weight(fy);
    // The far corner is x0 + 1 at full 32 bits, so the top cell is not wrapped.
    top_row = lerp_weighted(corner_gradient_dot(x0, y0, fx, fy),
                            corner_gradient_dot(x0 + 32'd1, y0, fx - ONE_F, fy), sx);
    bot_row = lerp_weighted(corner_gradient_dot(x0, y0 + 32'd1, fx, fy - ONE_F),
                            corner_gradient_dot(x0 + 32'd1, y0 + 32'd1,
                                                fx - ONE_F, fy - ONE_F), sx);
    mixed = lerp_weighted(top_row, bot_row, sy) + ONE_F;
    if (FRAC_BITS > 15) begin
      scaled = (mixed + (longint'(1) << (FRAC_BITS > 15 ? FRAC_BITS - 16 : 0)))
               >>> (FRAC_BITS > 15 ? FRAC_BITS - 15 : 0);
    end else begin
      scaled = mixed <<< (FRAC_BITS < 15 ? 15 - FRAC_BITS : 0);
    end
    if (scaled < 0) begin
      scaled = 0;
    end
    if (scaled > 65535) begin
      scaled = 65535;
    end
    return scaled[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Presents one coordinate pair, waits for it to be taken, then may idle.
  task automatic send_coord(input logic [31:0] xp, input logic [31:0] yp,
                            input bit pinned, input logic [15:0] pinned_noise);
    noise_expect_t e;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {yp, xp};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    e.x_pos = xp;
    e.y_pos = yp;
    e.noise = pinned ? pinned_noise : predict_noise(xp, yp);
    noise_expect_q.push_back(e);
    coords_sent++;
    if (!quiet_tail && sender_idles && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (noise_expect_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_coord(input int kind);
    logic [31:0] v;
    v = $urandom;
    case (kind)
      0: begin
        // Fraction at or next to a cell edge, or at the cell middle.
        case ($urandom_range(0, 4))
          0: v[15:0] = 16'h0000;
          1: v[15:0] = 16'hFFFF;
          2: v[15:0] = 16'h8000;
          3: v[15:0] = 16'h0001;
          default: v[15:0] = 16'hFFFE;
        endcase
      end
      1: v[31:16] = 16'hFFFF;
      2: v[31:16] = 16'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    noise_expect_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (noise_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected noise value %0d", m_axis_tdata));
      end else begin
        e = noise_expect_q.pop_front();
        noise_checked++;
        if (m_axis_tdata !== e.noise) begin
          report_mismatch($sformatf("x=%08h y=%08h noise got %0d want %0d",
                                    e.x_pos, e.y_pos, m_axis_tdata, e.noise));
        end
      end
    end
  end

  // Receiver stalls come in bursts; some stretches have none at all.
  always @(posedge clk) begin
    int stall_left;
    int calm_left;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!rst && !quiet_tail && calm_left == 0 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 99) == 0) begin
      calm_left = $urandom_range(20, 80);
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", noise_expect_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int kind;
    for (int r = 0; r <= QUARTER_STEPS; r++) begin
      quarter_sine_rom[r] = quarter_sine_entry(r);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_coord(directed_rows[i].x_pos, directed_rows[i].y_pos,
                 directed_rows[i].pinned, directed_rows[i].noise);
    end
    wait_all_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        sender_idles = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_ITEMS / 2) begin
        wait_all_results();
      end
      quiet_tail = (n >= RANDOM_ITEMS - 80);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        send_coord($urandom, $urandom, 1'b0, 16'd0);
      end else begin
        send_coord(pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
                   1'b0, 16'd0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (noise_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d coordinate pairs and checked %0d noise values,", coords_sent,
             noise_checked);
    $display("covering lattice points, cell edges and the top of the coordinate range.");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
